// ===== rtl/cubic_multibrot_escape_time_macros.svh =====
// assertion macros used by the checker file
`ifndef CUBIC_MULTIBROT_ESCAPE_TIME_MACROS_SVH
`define CUBIC_MULTIBROT_ESCAPE_TIME_MACROS_SVH

// property must hold at every clock edge outside reset
`define CMET_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition must never be seen outside reset
`define CMET_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/cmet_pkg.sv =====
// types, constants and helpers for the cubic multibrot escape-time block
package cmet_pkg;

   localparam int VAL_W               = 48;
   localparam int FRAC_BITS           = 36;
   localparam int HALF_W              = VAL_W / 2;
   localparam int ACC_W               = 2 * VAL_W;
   localparam int COORD_W             = 32;
   localparam int GRAY_W              = 8;
   localparam int OUT_ITER_W          = 16;
   localparam int LIMIT_W             = 28;
   localparam int LIMIT_SHIFT         = 20;
   localparam int ITER_WIDTH_DEF      = 16;
   localparam int COORD_FRAC_BITS_DEF = 26;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [LIMIT_W-1:0]    ESCAPE_LIMIT_RST = 28'd6553600;
   localparam logic [OUT_ITER_W-1:0] MAX_ITER_RST     = 16'd100;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_8000_0000_0000;

   typedef enum logic [0:0] {
      REG_ESCAPE_LIMIT = 1'b0,
      REG_MAX_ITER     = 1'b1
   } cmet_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COEF,
      ST_XA_GO,
      ST_XA_WAIT,
      ST_YB_GO,
      ST_YB_WAIT,
      ST_XX_GO,
      ST_XX_WAIT,
      ST_YY_GO,
      ST_YY_WAIT,
      ST_TEST,
      ST_DIV,
      ST_EMIT
   } cmet_state_type;

   typedef struct packed {
      logic                    ovf;
      logic signed [VAL_W-1:0] val;
   } cmet_sat_type;

   typedef struct packed {
      logic                    start;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
   } cmet_mul_req_type;

   typedef struct packed {
      logic                    done;
      logic                    ovf;
      logic signed [VAL_W-1:0] prod;
   } cmet_mul_rsp_type;

   // clamp a wide signed value into the Q12.36 range
   function automatic cmet_sat_type sat48(input logic signed [63:0] v);
      cmet_sat_type r;
      if (v > SAT_HI) begin
         r.ovf = 1'b1;
         r.val = SAT_HI[VAL_W-1:0];
      end else if (v < SAT_LO) begin
         r.ovf = 1'b1;
         r.val = SAT_LO[VAL_W-1:0];
      end else begin
         r.ovf = 1'b0;
         r.val = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/cmet_if.sv =====
// request and response channel interfaces
interface cmet_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] c_re;
   logic signed [31:0] c_im;

   modport source (output valid, c_re, c_im, input ready);
   modport sink   (input valid, c_re, c_im, output ready);
endinterface

interface cmet_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  gray;
   logic        escaped;
   logic [15:0] iterations;

   modport source (output valid, gray, escaped, iterations, input ready);
   modport sink   (input valid, gray, escaped, iterations, output ready);
endinterface

// ===== rtl/cmet_fmul.sv =====
// iterative Q12.36 multiplier: four 24x24 partial products, truncate toward zero, saturate
module cmet_fmul
   import cmet_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmet_mul_req_type mreq,
   output cmet_mul_rsp_type mrsp
);

   localparam logic [2:0] LAST_PH  = 3'd5;
   localparam logic [2:0] ISSUE_PH = 3'd4;
   localparam logic [59:0] MAG_LIM = {12'b0, 1'b1, 47'b0};

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    prod_vld_ff, prod_vld_in;
   logic [2:0]              ph_ff, ph_in;
   logic [VAL_W-1:0]        ma_ff, ma_in;
   logic [VAL_W-1:0]        mb_ff, mb_in;
   logic                    neg_ff, neg_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [VAL_W-1:0]        prod_ff, prod_in;
   logic [1:0]              prod_sh_ff, prod_sh_in;
   logic signed [VAL_W-1:0] res_ff, res_in;
   logic                    ovf_ff, ovf_in;

   logic [HALF_W-1:0] half_a;
   logic [HALF_W-1:0] half_b;
   logic [ACC_W-1:0]  prod_aligned;
   logic [59:0]       mag;

   assign half_a = ph_ff[0] ? ma_ff[VAL_W-1:HALF_W] : ma_ff[HALF_W-1:0];
   assign half_b = ph_ff[1] ? mb_ff[VAL_W-1:HALF_W] : mb_ff[HALF_W-1:0];
   assign mag    = acc_ff[ACC_W-1:FRAC_BITS];

   always_comb begin
      case (prod_sh_ff) inside
         2'd0:       prod_aligned = {{HALF_W{1'b0}}, {HALF_W{1'b0}}, prod_ff};
         2'd1, 2'd2: prod_aligned = {{HALF_W{1'b0}}, prod_ff, {HALF_W{1'b0}}};
         default:    prod_aligned = {prod_ff, {HALF_W{1'b0}}, {HALF_W{1'b0}}};
      endcase
   end

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      prod_vld_in = 1'b0;
      ph_in       = ph_ff;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      prod_sh_in  = prod_sh_ff;
      res_in      = res_ff;
      ovf_in      = ovf_ff;

      if (prod_vld_ff) begin
         acc_in = acc_ff + prod_aligned;
      end

      if (mreq.start) begin
         ma_in   = mreq.a[VAL_W-1] ? VAL_W'(-mreq.a) : VAL_W'(mreq.a);
         mb_in   = mreq.b[VAL_W-1] ? VAL_W'(-mreq.b) : VAL_W'(mreq.b);
         neg_in  = mreq.a[VAL_W-1] ^ mreq.b[VAL_W-1];
         acc_in  = '0;
         ph_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ph_ff < ISSUE_PH) begin
            prod_in     = VAL_W'(half_a * half_b);
            prod_sh_in  = ph_ff[1:0];
            prod_vld_in = 1'b1;
         end
         if (ph_ff == LAST_PH) begin
            done_in = 1'b1;
            busy_in = 1'b0;
            if (neg_ff) begin
               ovf_in = (mag > MAG_LIM);
               res_in = (mag > MAG_LIM) ? SAT_LO[VAL_W-1:0] : (~mag[VAL_W-1:0] + 1'b1);
            end else begin
               ovf_in = (mag > MAG_LIM - 60'd1);
               res_in = (mag > MAG_LIM - 60'd1) ? SAT_HI[VAL_W-1:0] : mag[VAL_W-1:0];
            end
         end
         ph_in = ph_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         done_ff     <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff      <= ph_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      prod_sh_ff <= prod_sh_in;
      res_ff     <= res_in;
      ovf_ff     <= ovf_in;
   end

   assign mrsp.done = done_ff;
   assign mrsp.ovf  = ovf_ff;
   assign mrsp.prod = res_ff;

endmodule

// ===== rtl/cubic_multibrot_escape_time.sv =====
// escape-time evaluator for the cubic multibrot set, z <= z^3 + c
//
// req_ch carries one point c (c_re, c_im, signed, COORD_FRAC_BITS fraction bits).
// rsp_ch returns one word per point: gray, escaped, iterations.
// Both channels use valid/ready; a word moves when both are high.
// csr_* is an APB-style port: escape_limit at byte 0, max_iter at byte 4.
// Registers should only be written while no point is in flight.
//
// One point is worked at a time; req_ch.ready is low from acceptance until
// the result has been placed in the output register.
// Each iteration runs four Q12.36 products through one shared 24x24
// multiplier (four partial products per product). A point that escapes
// also goes through a bit-serial restoring division for its gray level
// before the result is placed in the output register.
// A result waiting on a stalled receiver does not block acceptance of the
// next point; the finished result of that point waits in the sequencer.
// Synchronous reset returns the registers to escape_limit 100.0, max_iter 100
// and empties the output register.
module cubic_multibrot_escape_time
   import cmet_pkg::*;
#(
   parameter int ITER_WIDTH      = ITER_WIDTH_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cmet_req_if.sink              req_ch,
   cmet_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SH_L  = (COORD_FRAC_BITS <= FRAC_BITS) ? FRAC_BITS - COORD_FRAC_BITS : 0;
   localparam int SH_R  = (COORD_FRAC_BITS > FRAC_BITS) ? COORD_FRAC_BITS - FRAC_BITS : 0;
   localparam int NUM_W = ITER_WIDTH + GRAY_W;
   localparam int DCNT_W = $clog2(GRAY_W);
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(GRAY_W - 1);

   // control state
   cmet_state_type          state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]      escape_limit_ff, escape_limit_in;
   logic [OUT_ITER_W-1:0]   max_iter_ff, max_iter_in;

   // datapath
   logic signed [VAL_W-1:0] cr_ff, cr_in;
   logic signed [VAL_W-1:0] ci_ff, ci_in;
   logic                    cov_ff, cov_in;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic signed [VAL_W-1:0] y_ff, y_in;
   logic signed [VAL_W-1:0] x2_ff, x2_in;
   logic signed [VAL_W-1:0] y2_ff, y2_in;
   logic signed [VAL_W-1:0] a_ff, a_in;
   logic signed [VAL_W-1:0] b_ff, b_in;
   logic                    ov_ff, ov_in;
   logic                    esc_ff, esc_in;
   logic [ITER_WIDTH-1:0]   iter_ff, iter_in;
   logic [ITER_WIDTH-1:0]   lim_ff, lim_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [NUM_W-1:0]        dsh_ff, dsh_in;
   logic [GRAY_W-1:0]       q_ff, q_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [GRAY_W-1:0]       rsp_gray_ff, rsp_gray_in;
   logic                    rsp_esc_ff, rsp_esc_in;
   logic [OUT_ITER_W-1:0]   rsp_iter_ff, rsp_iter_in;

   cmet_mul_req_type        mreq;
   cmet_mul_rsp_type        mrsp;

   logic                    accept;
   logic                    rsp_free;
   logic                    req_ready_c;
   logic                    csr_wr;
   cmet_reg_type            csr_reg;
   logic signed [63:0]      cr_wide;
   logic signed [63:0]      ci_wide;
   cmet_sat_type            cr_conv;
   cmet_sat_type            ci_conv;
   logic signed [63:0]      x2_wide;
   logic signed [63:0]      y2_wide;
   cmet_sat_type            sat_a;
   cmet_sat_type            sat_b;
   cmet_sat_type            sat_sum;
   logic [31:0]             max_wide;
   logic [ITER_WIDTH-1:0]   lim_raw;
   logic [ITER_WIDTH-1:0]   iter_next;
   logic [31:0]             iter_wide;
   logic [VAL_W:0]          mag2;
   logic [VAL_W:0]          thr;
   logic                    escape_now;

   cmet_fmul u_fmul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = cmet_reg_type'(csr_paddr[2]);

   always_comb begin
      escape_limit_in = escape_limit_ff;
      max_iter_in     = max_iter_ff;
      if (csr_wr) begin
         unique case (csr_reg)
            REG_ESCAPE_LIMIT: escape_limit_in = csr_pwdata[LIMIT_W-1:0];
            REG_MAX_ITER:     max_iter_in     = csr_pwdata[OUT_ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_ESCAPE_LIMIT: csr_prdata = CSR_DATA_W'(escape_limit_ff);
         REG_MAX_ITER:     csr_prdata = CSR_DATA_W'(max_iter_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // coordinate scaling to Q12.36, floor on a right shift
   assign cr_wide = (64'(req_ch.c_re) <<< SH_L) >>> SH_R;
   assign ci_wide = (64'(req_ch.c_im) <<< SH_L) >>> SH_R;
   assign cr_conv = sat48(cr_wide);
   assign ci_conv = sat48(ci_wide);

   // iteration limit masked to the counter width, zero counts as one
   assign max_wide = 32'(max_iter_ff);
   assign lim_raw  = max_wide[ITER_WIDTH-1:0];

   assign x2_wide = 64'(x2_ff);
   assign y2_wide = 64'(y2_ff);
   assign sat_a   = sat48(x2_wide - (y2_wide + (y2_wide <<< 1)));
   assign sat_b   = sat48((x2_wide + (x2_wide <<< 1)) - y2_wide);
   assign sat_sum = sat48(64'(mrsp.prod) + ((state_ff == ST_YB_WAIT) ? 64'(ci_ff) : 64'(cr_ff)));

   assign iter_next  = iter_ff + 1'b1;
   assign iter_wide  = 32'(iter_ff);
   assign mag2       = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign thr        = {1'b0, escape_limit_ff, {LIMIT_SHIFT{1'b0}}};
   assign escape_now = ov_ff || (mag2 >= thr);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept) state_in = ST_COEF;
         ST_COEF:    state_in = ST_XA_GO;
         ST_XA_GO:   state_in = ST_XA_WAIT;
         ST_XA_WAIT: if (mrsp.done) state_in = ST_YB_GO;
         ST_YB_GO:   state_in = ST_YB_WAIT;
         ST_YB_WAIT: if (mrsp.done) state_in = ST_XX_GO;
         ST_XX_GO:   state_in = ST_XX_WAIT;
         ST_XX_WAIT: if (mrsp.done) state_in = ST_YY_GO;
         ST_YY_GO:   state_in = ST_YY_WAIT;
         ST_YY_WAIT: if (mrsp.done) state_in = ST_TEST;
         ST_TEST: begin
            if (escape_now) state_in = ST_DIV;
            else if (iter_next == lim_ff) state_in = ST_EMIT;
            else state_in = ST_COEF;
         end
         ST_DIV:     if (dcnt_ff == DIV_LAST) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready_c = 1'b0;
      mreq.start  = 1'b0;
      mreq.a      = x_ff;
      mreq.b      = a_ff;
      unique case (state_ff)
         ST_IDLE:  req_ready_c = !reset;
         ST_XA_GO: begin
            mreq.start = 1'b1;
         end
         ST_YB_GO: begin
            mreq.start = 1'b1;
            mreq.a     = y_ff;
            mreq.b     = b_ff;
         end
         ST_XX_GO: begin
            mreq.start = 1'b1;
            mreq.b     = x_ff;
         end
         ST_YY_GO: begin
            mreq.start = 1'b1;
            mreq.a     = y_ff;
            mreq.b     = y_ff;
         end
         default: ;
      endcase
   end

   assign req_ch.ready = req_ready_c;

   // datapath updates
   always_comb begin
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      cov_in   = cov_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      x2_in    = x2_ff;
      y2_in    = y2_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      ov_in    = ov_ff;
      esc_in   = esc_ff;
      iter_in  = iter_ff;
      lim_in   = lim_ff;
      num_in   = num_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      rsp_gray_in  = rsp_gray_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cr_in   = cr_conv.val;
               ci_in   = ci_conv.val;
               cov_in  = cr_conv.ovf || ci_conv.ovf;
               x_in    = '0;
               y_in    = '0;
               x2_in   = '0;
               y2_in   = '0;
               iter_in = '0;
               lim_in  = (lim_raw == '0) ? ITER_WIDTH'(1) : lim_raw;
            end
         end
         ST_COEF: begin
            a_in  = sat_a.val;
            b_in  = sat_b.val;
            ov_in = cov_ff || sat_a.ovf || sat_b.ovf;
         end
         ST_XA_WAIT: begin
            if (mrsp.done) begin
               x_in  = sat_sum.val;
               ov_in = ov_ff || mrsp.ovf || sat_sum.ovf;
            end
         end
         ST_YB_WAIT: begin
            if (mrsp.done) begin
               y_in  = sat_sum.val;
               ov_in = ov_ff || mrsp.ovf || sat_sum.ovf;
            end
         end
         ST_XX_WAIT: begin
            if (mrsp.done) begin
               x2_in = mrsp.prod;
               ov_in = ov_ff || mrsp.ovf;
            end
         end
         ST_YY_WAIT: begin
            if (mrsp.done) begin
               y2_in = mrsp.prod;
               ov_in = ov_ff || mrsp.ovf;
            end
         end
         ST_TEST: begin
            iter_in = iter_next;
            esc_in  = escape_now;
            // numerator is iterations*255, divisor pre-shifted for the top quotient bit
            num_in  = {iter_next, {GRAY_W{1'b0}}} - NUM_W'(iter_next);
            dsh_in  = NUM_W'({lim_ff, {(GRAY_W-1){1'b0}}});
            q_in    = '0;
            dcnt_in = '0;
         end
         ST_DIV: begin
            if (num_ff >= dsh_ff) begin
               num_in = num_ff - dsh_ff;
               q_in   = {q_ff[GRAY_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[GRAY_W-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            dcnt_in = dcnt_ff + 1'b1;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_gray_in  = esc_ff ? q_ff : '0;
               rsp_esc_in   = esc_ff;
               rsp_iter_in  = iter_wide[OUT_ITER_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         escape_limit_ff <= ESCAPE_LIMIT_RST;
         max_iter_ff     <= MAX_ITER_RST;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         escape_limit_ff <= escape_limit_in;
         max_iter_ff     <= max_iter_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      cov_ff      <= cov_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ov_ff       <= ov_in;
      esc_ff      <= esc_in;
      iter_ff     <= iter_in;
      lim_ff      <= lim_in;
      num_ff      <= num_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      dcnt_ff     <= dcnt_in;
      rsp_gray_ff <= rsp_gray_in;
      rsp_esc_ff  <= rsp_esc_in;
      rsp_iter_ff <= rsp_iter_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.gray       = rsp_gray_ff;
   assign rsp_ch.escaped    = rsp_esc_ff;
   assign rsp_ch.iterations = rsp_iter_ff;

endmodule

// ===== rtl/cmet_checker.sv =====
// port-level checker for the escape-time block, bound to the top level
`include "cubic_multibrot_escape_time_macros.svh"

module cmet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_gray,
   input logic        rsp_escaped,
   input logic [15:0] rsp_iterations
);

   // a stalled word must hold
   `CMET_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gray) && $stable(rsp_escaped) && $stable(rsp_iterations), "rsp word changed while stalled")

   // one point at a time
   `CMET_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while a point is in flight")

   `CMET_ASSERT_NEVER(a_iter_nonzero, clock, reset, rsp_valid && rsp_iterations == 16'd0, "result with zero iterations")

   // points inside the set are black
   `CMET_ASSERT(a_inside_black, clock, reset, rsp_valid && !rsp_escaped |-> rsp_gray == 8'd0, "non-escaped point with nonzero gray")

endmodule

bind cubic_multibrot_escape_time cmet_checker u_cmet_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_gray       (rsp_ch.gray),
   .rsp_escaped    (rsp_ch.escaped),
   .rsp_iterations (rsp_ch.iterations)
);

// ===== test/tb.sv =====
// testbench for the cubic multibrot escape-time block: random and directed points, self-checked
`timescale 1ns / 100ps

module tb
   import cmet_pkg::*;
();

   localparam int ONE          = 1 << 26;       // 1.0 in Q6.26
   localparam int COORD_SHIFT  = 10;            // Q6.26 -> Q12.36
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 3000;

   localparam logic signed [63:0] Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = 64'shFFFF_8000_0000_0000;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_type;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
   } point_type;

   typedef struct packed {
      logic [7:0]  gray;
      logic        escaped;
      logic [15:0] iterations;
   } pixel_type;

   typedef struct packed {
      logic               ovf;
      logic signed [63:0] v;
   } fixed_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cmet_req_if req_ch();
   cmet_rsp_if rsp_ch();

   cubic_multibrot_escape_time DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copies of the block's registers
   logic [27:0] escape_limit_q = ESCAPE_LIMIT_RST;
   logic [15:0] max_iter_q     = MAX_ITER_RST;

   point_type point_q[$];
   pixel_type pixel_q[$];
   idle_type  idle_mode      = IDLE_NONE;
   logic      pressure_on    = 1'b0;
   logic      pressure_taken = 1'b0;
   int        hold_left      = 0;
   int        quiet_cycles   = 0;
   int        fail_count     = 0;

   always #6 clock = ~clock;

   function automatic fixed_type clamp48(input logic signed [63:0] v);
      fixed_type r;
      r.ovf = 1'b0;
      r.v   = v;
      if (v > Q_MAX) begin
         r.ovf = 1'b1;
         r.v   = Q_MAX;
      end else if (v < Q_MIN) begin
         r.ovf = 1'b1;
         r.v   = Q_MIN;
      end
      return r;
   endfunction

   // Q12.36 product, magnitude truncated toward zero, then clamped
   function automatic fixed_type qmul(input logic signed [63:0] a, input logic signed [63:0] b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] wa;
      logic [127:0] wb;
      logic [127:0] full;
      logic [63:0]  mag;
      fixed_type    r;
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      wa   = ma;
      wb   = mb;
      full = wa * wb;
      mag  = full[99:36];
      r.ovf = 1'b0;
      if ((a < 0) != (b < 0)) begin
         if (mag > 64'h0000_8000_0000_0000) begin
            r.ovf = 1'b1;
            r.v   = Q_MIN;
         end else begin
            r.v = -$signed(mag);
         end
      end else if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
         r.ovf = 1'b1;
         r.v   = Q_MAX;
      end else begin
         r.v = $signed(mag);
      end
      return r;
   endfunction

   // escape-time result for one point under the current register values
   function automatic pixel_type render_point(input logic signed [31:0] re,
                                              input logic signed [31:0] im);
      logic signed [63:0] cr;
      logic signed [63:0] ci;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] x2;
      logic signed [63:0] y2;
      logic signed [63:0] pa;
      logic signed [63:0] pb;
      logic [63:0]        bound;
      logic [63:0]        mag2;
      logic [31:0]        n;
      logic [31:0]        cap;
      logic [31:0]        shade;
      logic               c_ovf;
      logic               ovf;
      logic               hit;
      fixed_type          t;
      pixel_type          p;
      cr = re;
      ci = im;
      t  = clamp48(cr <<< COORD_SHIFT);
      cr = t.v;
      c_ovf = t.ovf;
      t  = clamp48(ci <<< COORD_SHIFT);
      ci = t.v;
      c_ovf |= t.ovf;
      cap = max_iter_q;
      if (cap == 0) cap = 1;
      bound = escape_limit_q;
      bound = bound << 20;
      x = 0; y = 0; x2 = 0; y2 = 0;
      n = 0;
      hit = 1'b0;
      while (n < cap && !hit) begin
         ovf = c_ovf;
         t = clamp48(x2 - 3 * y2);    ovf |= t.ovf; pa = t.v;
         t = clamp48(3 * x2 - y2);    ovf |= t.ovf; pb = t.v;
         t = qmul(x, pa);             ovf |= t.ovf;
         t = clamp48(t.v + cr);       ovf |= t.ovf; x = t.v;
         t = qmul(y, pb);             ovf |= t.ovf;
         t = clamp48(t.v + ci);       ovf |= t.ovf; y = t.v;
         t = qmul(x, x);              ovf |= t.ovf; x2 = t.v;
         t = qmul(y, y);              ovf |= t.ovf; y2 = t.v;
         n = n + 1;
         mag2 = x2 + y2;
         if (ovf || mag2 >= bound) hit = 1'b1;
      end
      shade        = (n * 255) / cap;
      p.gray       = hit ? shade[7:0] : 8'd0;
      p.escaped    = hit;
      p.iterations = n[15:0];
      return p;
   endfunction

   function automatic logic sender_idles();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99, 0) < 59;
         IDLE_BOTH:   return $urandom_range(99, 0) < 10;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(99, 0) < 59;
         IDLE_BOTH:     return $urandom_range(99, 0) < 10;
         default:       return 1'b0;
      endcase
   endfunction

   // point in [-1.5, 1.5] on both axes, where escape times vary most
   function automatic point_type near_point();
      point_type p;
      p.re = int'($urandom_range(3 * ONE, 0)) - 3 * ONE / 2;
      p.im = int'($urandom_range(3 * ONE, 0)) - 3 * ONE / 2;
      return p;
   endfunction

   // |c_re| >= 2.0 guarantees a quick escape
   function automatic point_type far_point();
      point_type p;
      int        mag;
      mag  = int'($urandom_range(32'h7FFF_FFFF, 2 * ONE));
      p.re = $urandom_range(1, 0) ? -mag : mag;
      p.im = $urandom;
      return p;
   endfunction

   function automatic point_type mixed_point();
      point_type p;
      int        pick;
      pick = $urandom_range(9, 0);
      if (pick < 7) begin
         p = near_point();
      end else if (pick < 9) begin
         p.re = $urandom;
         p.im = $urandom;
      end else begin
         p.re = int'($urandom_range(255, 0)) - 128;
         p.im = int'($urandom_range(255, 0)) - 128;
      end
      return p;
   endfunction

   task automatic push_point(input logic [31:0] re, input logic [31:0] im);
      point_type p;
      p.re = re;
      p.im = im;
      point_q.push_back(p);
   endtask

   task automatic csr_write(input cmet_reg_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ESCAPE_LIMIT: escape_limit_q = value[27:0];
         REG_MAX_ITER:     max_iter_q     = value[15:0];
         default: ;
      endcase
   endtask

   // wait until every point is in and every result is out
   task automatic drain();
      while (point_q.size() != 0 || req_ch.valid || pixel_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input logic [27:0] limit, input logic [15:0] iters,
                            input idle_type mode, input int count, input logic far_only);
      int k;
      drain();
      csr_write(REG_ESCAPE_LIMIT, {4'd0, limit});
      csr_write(REG_MAX_ITER, {16'd0, iters});
      idle_mode = mode;
      for (k = 0; k < count; k++)
         point_q.push_back(far_only ? far_point() : mixed_point());
   endtask

   // sender
   always @(posedge clock) begin : drive_points
      point_type next_pt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            pixel_q.push_back(render_point(req_ch.c_re, req_ch.c_im));
         if (!req_ch.valid || req_ch.ready) begin
            if (point_q.size() != 0 && !sender_idles()) begin
               next_pt = point_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.c_re  <= next_pt.re;
               req_ch.c_im  <= next_pt.im;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (pressure_on && !pressure_taken) begin
         rsp_ch.ready   <= 1'b0;
         hold_left      <= HOLD_CYCLES;
         pressure_taken <= 1'b1;
      end else begin
         rsp_ch.ready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pixel_q.size() == 0) begin
            $error("result word with no point outstanding");
            fail_count++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_ch.gray !== want.gray) begin
               $error("gray: expected %0d, got %0d", want.gray, rsp_ch.gray);
               fail_count++;
            end
            if (rsp_ch.escaped !== want.escaped) begin
               $error("escaped: expected %0d, got %0d", want.escaped, rsp_ch.escaped);
               fail_count++;
            end
            if (rsp_ch.iterations !== want.iterations) begin
               $error("iterations: expected %0d, got %0d", want.iterations,
                      rsp_ch.iterations);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.c_re  = '0;
      req_ch.c_im  = '0;
      rsp_ch.ready = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: limit 100.0, 100 iterations
      push_point(32'd0, 32'd0);
      push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h8000_0000);
      push_point(32'h7FFF_FFFF, 32'h8000_0000);
      push_point(32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'd0, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'd0);
      push_point(ONE, 32'd0);
      push_point(-ONE, 32'd0);
      push_point(32'd0, ONE);
      push_point(32'd0, -ONE);
      push_point(-32'sd1, -32'sd1);
      push_point(32'd1, 32'd1);
      push_point(ONE / 2, ONE / 2);
      push_point(2 * ONE, 32'd0);
      push_point(32'd0, 2 * ONE);
      push_point(-2 * ONE, -2 * ONE);
      push_point(32'h5555_5555, 32'hAAAA_AAAA);
      push_point(32'hAAAA_AAAA, 32'h5555_5555);

      run_phase(28'd262144, 16'd16, IDLE_NONE, 150, 1'b0);
      run_phase(28'd6553600, 16'd32, IDLE_SENDER, 150, 1'b0);
      // zero limit: everything escapes on the first iteration
      run_phase(28'd0, 16'd65535, IDLE_RECEIVER, 40, 1'b0);
      // huge limit: only overflow makes a point escape
      run_phase(28'hFFF_FFFF, 16'd8, IDLE_BOTH, 120, 1'b0);
      run_phase(28'd65536, 16'd1, IDLE_SENDER, 50, 1'b0);
      // iteration limit of zero acts as one
      run_phase(28'hFFF_FFFF, 16'd0, IDLE_RECEIVER, 40, 1'b0);

      // c = 1.0 and -1.0 escape exactly on the fourth iteration
      drain();
      csr_write(REG_ESCAPE_LIMIT, 32'd6553600);
      csr_write(REG_MAX_ITER, 32'd4);
      idle_mode   = IDLE_NONE;
      pressure_on = 1'b1;
      push_point(ONE, 32'd0);
      push_point(-ONE, 32'd0);
      repeat (100) point_q.push_back(mixed_point());

      run_phase(28'd6553600, 16'd65535, IDLE_BOTH, 40, 1'b1);
      run_phase(28'd1, 16'd12, IDLE_RECEIVER, 60, 1'b0);

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cmet_pkg.sv
rtl/cmet_if.sv
rtl/cmet_fmul.sv
rtl/cubic_multibrot_escape_time.sv
rtl/cmet_checker.sv
test/tb.sv
